// ===== sv/mmm_pkg.sv =====
// Package for the matrix multiply block: sizes, codes and controller/datapath interface types.
package mmm_pkg;

  // Largest matrix dimension; the store and the 3-bit row/column indexes cap it at 8
  localparam int MAX_DIM    = 8;
  localparam int DIM_LIMIT  = 8;
  localparam int DIM_CAP    = (MAX_DIM < DIM_LIMIT) ? MAX_DIM : DIM_LIMIT;

  localparam int ELEM_W     = 16;
  localparam int PROD_W     = 32;
  localparam int ACC_W      = 35;
  localparam int ADDR_W     = 6;
  localparam int DIM_W      = 4;
  localparam int IDX_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4;

  // Input function codes
  typedef enum logic [1:0] {
    FUNC_LOAD_A = 2'd0,
    FUNC_LOAD_B = 2'd1,
    FUNC_START  = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_A_ROWS      = 3'd0,
    CFG_A_COLS      = 3'd1,
    CFG_B_ROWS      = 3'd2,
    CFG_B_COLS      = 3'd3,
    CFG_TRANSPOSE_A = 3'd4,
    CFG_TRANSPOSE_B = 3'd5
  } cfg_idx_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_EMIT,
    ST_ERR
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic             issue;     // one multiply-accumulate term enters the pipeline
    logic             first;     // first term of an element: restart the sum
    logic             lastk;     // last term of an element
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
    logic [IDX_W-1:0] k;
    logic             load_out;  // load the output register
    logic             err;       // the loaded result is a dimension error
    logic             last;      // the loaded result ends the multiply
  } mmm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [DIM_W-1:0] m;
    logic [DIM_W-1:0] n;
    logic [DIM_W-1:0] kk;
    logic             empty;
    logic             mismatch;
    logic             acc_done;  // accumulator holds a finished element
    logic             out_free;  // output register can take a result this cycle
  } mmm_status_t;

endpackage

// ===== sv/mmm_ctrl.sv =====
// Sequencer of the matrix multiply: walks rows, columns and inner terms of C.
module mmm_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  mmm_pkg::mmm_status_t stat,
  output logic                 busy,
  output mmm_pkg::mmm_cmd_t    cmd
);

  mmm_pkg::ctrl_state_t state_r, state_nxt;
  logic [mmm_pkg::IDX_W-1:0] i_r, i_nxt;
  logic [mmm_pkg::IDX_W-1:0] j_r, j_nxt;
  logic [mmm_pkg::IDX_W-1:0] k_r, k_nxt;

  logic last_k, last_i, last_j;

  assign last_k = ({1'b0, k_r} == (stat.kk - 4'd1));
  assign last_i = ({1'b0, i_r} == (stat.m - 4'd1));
  assign last_j = ({1'b0, j_r} == (stat.n - 4'd1));
  assign busy   = (state_r != mmm_pkg::ST_IDLE);

  // State and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mmm_pkg::ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    k_nxt        = k_r;
    cmd          = '0;
    cmd.i        = i_r;
    cmd.j        = j_r;
    cmd.k        = k_r;
    unique case (state_r)
      mmm_pkg::ST_IDLE: begin
        if (start && !stat.empty) begin
          i_nxt = '0;
          j_nxt = '0;
          k_nxt = '0;
          state_nxt = stat.mismatch ? mmm_pkg::ST_ERR : mmm_pkg::ST_ISSUE;
        end
      end
      mmm_pkg::ST_ISSUE: begin
        cmd.issue = 1'b1;
        cmd.first = (k_r == '0);
        cmd.lastk = last_k;
        if (last_k) begin
          state_nxt = mmm_pkg::ST_DRAIN;
        end else begin
          k_nxt = k_r + 3'd1;
        end
      end
      mmm_pkg::ST_DRAIN: begin
        if (stat.acc_done) begin
          state_nxt = mmm_pkg::ST_EMIT;
        end
      end
      mmm_pkg::ST_EMIT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          cmd.last     = last_i && last_j;
          k_nxt        = '0;
          if (last_i && last_j) begin
            state_nxt = mmm_pkg::ST_IDLE;
          end else begin
            state_nxt = mmm_pkg::ST_ISSUE;
            if (last_j) begin
              j_nxt = '0;
              i_nxt = i_r + 3'd1;
            end else begin
              j_nxt = j_r + 3'd1;
            end
          end
        end
      end
      mmm_pkg::ST_ERR: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          cmd.err      = 1'b1;
          cmd.last     = 1'b1;
          state_nxt    = mmm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mmm_pkg::ST_IDLE;
      end
    endcase
  end

  // A start with non-empty matrices always leaves idle
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mmm_pkg::ST_IDLE) && start && !stat.empty |=> (state_r != mmm_pkg::ST_IDLE))
    else $error("start with non-empty matrices did not begin a multiply");

  // No new term enters while a finished element waits in the accumulator
  assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.issue && stat.acc_done))
    else $error("term issued over a finished accumulation");

  // Going back to idle always loads the final result of the multiply
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != mmm_pkg::ST_IDLE) && (state_nxt == mmm_pkg::ST_IDLE)
      |-> cmd.load_out && cmd.last)
    else $error("multiply ended without a final result");

endmodule

// ===== sv/mmm_dpath.sv =====
// Datapath of the matrix multiply: config, element stores, MAC pipeline, output register.
module mmm_dpath (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [mmm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [mmm_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                  we_a,
  input  logic                                  we_b,
  input  logic [mmm_pkg::ADDR_W-1:0]            wr_addr,
  input  logic [mmm_pkg::ELEM_W-1:0]            wr_data,
  input  mmm_pkg::mmm_cmd_t                     cmd,
  output mmm_pkg::mmm_status_t                  stat,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [mmm_pkg::ACC_W-1:0]      out_product_value,
  output logic [mmm_pkg::IDX_W-1:0]             out_row,
  output logic [mmm_pkg::IDX_W-1:0]             out_col,
  output logic                                  out_dim_error,
  output logic                                  out_last
);

  localparam int DEPTH = 1 << mmm_pkg::ADDR_W;
  localparam logic [mmm_pkg::DIM_W-1:0] CAP = mmm_pkg::DIM_W'(mmm_pkg::DIM_CAP);

  // Configuration registers
  logic [mmm_pkg::DIM_W-1:0] a_rows_r, a_cols_r, b_rows_r, b_cols_r;
  logic                      transpose_a_r, transpose_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_rows_r      <= 4'd8;
      a_cols_r      <= 4'd8;
      b_rows_r      <= 4'd8;
      b_cols_r      <= 4'd8;
      transpose_a_r <= 1'b0;
      transpose_b_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mmm_pkg::CFG_A_ROWS:      a_rows_r      <= cfg_data;
        mmm_pkg::CFG_A_COLS:      a_cols_r      <= cfg_data;
        mmm_pkg::CFG_B_ROWS:      b_rows_r      <= cfg_data;
        mmm_pkg::CFG_B_COLS:      b_cols_r      <= cfg_data;
        mmm_pkg::CFG_TRANSPOSE_A: transpose_a_r <= cfg_data[0];
        mmm_pkg::CFG_TRANSPOSE_B: transpose_b_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Effective dimensions, capped
  logic [mmm_pkg::DIM_W-1:0] ar, ac, br, bc, kk1, kk2;
  assign ar  = (a_rows_r > CAP) ? CAP : a_rows_r;
  assign ac  = (a_cols_r > CAP) ? CAP : a_cols_r;
  assign br  = (b_rows_r > CAP) ? CAP : b_rows_r;
  assign bc  = (b_cols_r > CAP) ? CAP : b_cols_r;
  assign kk1 = transpose_a_r ? ar : ac;
  assign kk2 = transpose_b_r ? bc : br;

  // Store addresses for the issued term
  logic [mmm_pkg::IDX_W-1:0] a_row, a_col, b_row, b_col;
  logic [6:0]                a_lin, b_lin;
  assign a_row = transpose_a_r ? cmd.k : cmd.i;
  assign a_col = transpose_a_r ? cmd.i : cmd.k;
  assign b_row = transpose_b_r ? cmd.j : cmd.k;
  assign b_col = transpose_b_r ? cmd.k : cmd.j;
  assign a_lin = 7'(a_row) * 7'(ac) + 7'(a_col);
  assign b_lin = 7'(b_row) * 7'(bc) + 7'(b_col);

  // Element stores, one write and one registered read each
  logic [mmm_pkg::ELEM_W-1:0] mem_a [DEPTH];
  logic [mmm_pkg::ELEM_W-1:0] mem_b [DEPTH];
  logic signed [mmm_pkg::ELEM_W-1:0] rd_a_r, rd_b_r;

  always_ff @(posedge clk) begin
    if (we_a) begin
      mem_a[wr_addr] <= wr_data;
    end
    rd_a_r <= mem_a[a_lin[mmm_pkg::ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (we_b) begin
      mem_b[wr_addr] <= wr_data;
    end
    rd_b_r <= mem_b[b_lin[mmm_pkg::ADDR_W-1:0]];
  end

  // Pipeline tags: read stage, multiply stage, accumulate done
  logic v1_r, first1_r, last1_r;
  logic v2_r, first2_r, last2_r;
  logic acc_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      acc_done_r <= 1'b0;
    end else begin
      v1_r       <= cmd.issue;
      v2_r       <= v1_r;
      acc_done_r <= v2_r && last2_r;
    end
  end

  always_ff @(posedge clk) begin
    first1_r <= cmd.first;
    last1_r  <= cmd.lastk;
    first2_r <= first1_r;
    last2_r  <= last1_r;
  end

  // Multiply, then exact accumulate
  logic signed [mmm_pkg::PROD_W-1:0] prod_r;
  logic signed [mmm_pkg::ACC_W-1:0]  acc_r, acc_nxt, prod_ext;

  assign prod_ext = {{(mmm_pkg::ACC_W-mmm_pkg::PROD_W){prod_r[mmm_pkg::PROD_W-1]}}, prod_r};
  assign acc_nxt  = first2_r ? prod_ext : (acc_r + prod_ext);

  always_ff @(posedge clk) begin
    prod_r <= rd_a_r * rd_b_r;
    if (v2_r) begin
      acc_r <= acc_nxt;
    end
  end

  // Output register
  logic out_valid_r;
  logic out_free;
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_product_value <= cmd.err ? '0 : acc_r;
      out_row           <= cmd.err ? '0 : cmd.i;
      out_col           <= cmd.err ? '0 : cmd.j;
      out_dim_error     <= cmd.err;
      out_last          <= cmd.last;
    end
  end

  assign out_valid     = out_valid_r;
  assign stat.m        = transpose_a_r ? ac : ar;
  assign stat.n        = transpose_b_r ? br : bc;
  assign stat.kk       = kk1;
  assign stat.empty    = (ar == '0) || (ac == '0) || (br == '0) || (bc == '0);
  assign stat.mismatch = (kk1 != kk2);
  assign stat.acc_done = acc_done_r;
  assign stat.out_free = out_free;

  // A held result is never overwritten
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || !out_stall))
    else $error("output register loaded while a stalled result is held");

  // An error result always ends its multiply
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_dim_error |-> out_last)
    else $error("dimension error result without last");

  // A stalled result stays valid and unchanged
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_product_value) &&
      $stable(out_row) && $stable(out_col) && $stable(out_last))
    else $error("stalled result changed");

endmodule

// ===== sv/matrix_matrix_multiply.sv =====
// Top level of the matrix multiply block C = op(A) x op(B) in Q8.8 / Q19.16.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+------------------------------------------------
//   input    | in_valid / in_stall   | in_func, in_element_index, in_element_value
//   result   | out_valid / out_stall | out_product_value, out_row, out_col,
//            |                       | out_dim_error, out_last
//   config   | cfg_we                | cfg_index, cfg_data
//
// A load writes its store directly; loads can follow each other every cycle while in_stall is low.
// A start computes the elements of C one at a time, each a sum of K terms (K = inner dimension),
// through the single read port of each store feeding one multiply-accumulate pipeline.
// in_stall is high from an accepted start with non-empty matrices until its last result is loaded.
// out_stall holds the output register; the sequencer waits while it is full and stalled.
// Reset (rst_n low, synchronous) sets all counts to 8, transposes off; stores are unset.
module matrix_matrix_multiply (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [mmm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mmm_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           in_func,
  input  logic [mmm_pkg::ADDR_W-1:0]           in_element_index,
  input  logic signed [mmm_pkg::ELEM_W-1:0]    in_element_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [mmm_pkg::ACC_W-1:0]     out_product_value,
  output logic [mmm_pkg::IDX_W-1:0]            out_row,
  output logic [mmm_pkg::IDX_W-1:0]            out_col,
  output logic                                 out_dim_error,
  output logic                                 out_last
);

  mmm_pkg::mmm_cmd_t    cmd;
  mmm_pkg::mmm_status_t stat;
  logic                 busy;
  logic                 in_xfer;

  // Input transfer decode
  assign in_stall = busy;
  assign in_xfer  = in_valid && !busy;

  mmm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_xfer && (in_func == mmm_pkg::FUNC_START)),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  mmm_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .we_a              (in_xfer && (in_func == mmm_pkg::FUNC_LOAD_A)),
    .we_b              (in_xfer && (in_func == mmm_pkg::FUNC_LOAD_B)),
    .wr_addr           (in_element_index),
    .wr_data           (in_element_value),
    .cmd               (cmd),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_product_value (out_product_value),
    .out_row           (out_row),
    .out_col           (out_col),
    .out_dim_error     (out_dim_error),
    .out_last          (out_last)
  );

endmodule

// ===== test/matrix_matrix_multiply_tb.sv =====
// Self-checking testbench for the matrix multiply block: loads, products, dimension errors.
module matrix_matrix_multiply_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEMS_TARGET = 330;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int LAT_PAD      = 2 * (mmm_pkg::DIM_CAP + 4) + 8;  // drain margin after last result
  localparam int HOLD_CYCLES  = 600;
  localparam int PRINT_CAP    = 30;
  localparam int STORE_DEPTH  = 1 << mmm_pkg::ADDR_W;

  // One element of C as seen on the result channel
  typedef struct packed {
    logic [mmm_pkg::ACC_W-1:0] product;
    logic [mmm_pkg::IDX_W-1:0] row;
    logic [mmm_pkg::IDX_W-1:0] col;
    logic                      dim_error;
    logic                      last;
  } product_t;

  // Mirror of the block's stores and registers, plus the queue of pending products
  class product_checker;
    logic signed [mmm_pkg::ELEM_W-1:0] a_store [STORE_DEPTH];
    logic signed [mmm_pkg::ELEM_W-1:0] b_store [STORE_DEPTH];
    logic [mmm_pkg::DIM_W-1:0]         a_rows, a_cols, b_rows, b_cols;
    bit                                ta, tb;
    product_t                          pending_products [$];
    int                                errors;
    int                                checked;

    function new();
      a_rows = 4'd8;
      a_cols = 4'd8;
      b_rows = 4'd8;
      b_cols = 4'd8;
      ta = 1'b0;
      tb = 1'b0;
      errors = 0;
      checked = 0;
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= PRINT_CAP) $display("ERROR @%0t: %s", $time, msg);
    endfunction

    function int capped(int v);
      return (v < mmm_pkg::DIM_CAP) ? v : mmm_pkg::DIM_CAP;
    endfunction

    // Append one expected result at the tail
    function void queue_product(product_t p);
      pending_products.insert(pending_products.size(), p);
    endfunction

    function void set_reg(mmm_pkg::cfg_idx_t idx, logic [mmm_pkg::CFG_DATA_W-1:0] v);
      case (idx)
        mmm_pkg::CFG_A_ROWS:      a_rows = v;
        mmm_pkg::CFG_A_COLS:      a_cols = v;
        mmm_pkg::CFG_B_ROWS:      b_rows = v;
        mmm_pkg::CFG_B_COLS:      b_cols = v;
        mmm_pkg::CFG_TRANSPOSE_A: ta = v[0];
        mmm_pkg::CFG_TRANSPOSE_B: tb = v[0];
        default: ;
      endcase
    endfunction

    // C = op(A) x op(B), exact sums, row by row
    function void predict_product();
      int       ar, ac, br, bc, m, k1, k2, n, pa, pb;
      longint   acc;
      product_t r;
      ar = capped(int'(a_rows));
      ac = capped(int'(a_cols));
      br = capped(int'(b_rows));
      bc = capped(int'(b_cols));
      if (ar == 0 || ac == 0 || br == 0 || bc == 0) return;
      m  = ta ? ac : ar;
      k1 = ta ? ar : ac;
      k2 = tb ? bc : br;
      n  = tb ? br : bc;
      r = '0;
      // inner dimensions disagree: single error marker
      if (k1 != k2) begin
        r.dim_error = 1'b1;
        r.last = 1'b1;
        queue_product(r);
        return;
      end
      for (int i = 0; i < m; i++) begin
        for (int j = 0; j < n; j++) begin
          acc = 0;
          for (int k = 0; k < k1; k++) begin
            pa = (ta ? k * ac + i : i * ac + k) % STORE_DEPTH;
            pb = (tb ? j * bc + k : k * bc + j) % STORE_DEPTH;
            acc += longint'(a_store[pa]) * longint'(b_store[pb]);
          end
          r.product = acc[mmm_pkg::ACC_W-1:0];
          r.row = mmm_pkg::IDX_W'(i);
          r.col = mmm_pkg::IDX_W'(j);
          r.last = (i == m - 1) && (j == n - 1);
          queue_product(r);
        end
      end
    endfunction

    function void note_transfer(logic [1:0] f, logic [mmm_pkg::ADDR_W-1:0] idx,
                                logic [mmm_pkg::ELEM_W-1:0] v);
      case (f)
        mmm_pkg::FUNC_LOAD_A: a_store[idx] = v;
        mmm_pkg::FUNC_LOAD_B: b_store[idx] = v;
        mmm_pkg::FUNC_START:  predict_product();
        default: ;
      endcase
    endfunction

    function void check_product(logic [mmm_pkg::ACC_W-1:0] product,
                                logic [mmm_pkg::IDX_W-1:0] row,
                                logic [mmm_pkg::IDX_W-1:0] col, logic dim_error,
                                logic last);
      product_t want;
      checked++;
      if (pending_products.size() == 0) begin
        report($sformatf("unexpected result: value %0h row %0d col %0d err %0b last %0b",
                         product, row, col, dim_error, last));
        return;
      end
      want = pending_products.pop_front();
      if (product !== want.product || row !== want.row || col !== want.col ||
          dim_error !== want.dim_error || last !== want.last) begin
        report($sformatf("got %0h r%0d c%0d e%0b l%0b, wanted %0h r%0d c%0d e%0b l%0b",
                         product, row, col, dim_error, last, want.product, want.row,
                         want.col, want.dim_error, want.last));
      end
    endfunction
  endclass

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              cfg_we = 1'b0;
  logic [mmm_pkg::CFG_IDX_W-1:0]     cfg_index = mmm_pkg::CFG_A_ROWS;
  logic [mmm_pkg::CFG_DATA_W-1:0]    cfg_data = '0;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic [1:0]                        in_func = mmm_pkg::FUNC_NONE;
  logic [mmm_pkg::ADDR_W-1:0]        in_element_index = '0;
  logic signed [mmm_pkg::ELEM_W-1:0] in_element_value = '0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic signed [mmm_pkg::ACC_W-1:0]  out_product_value;
  logic [mmm_pkg::IDX_W-1:0]         out_row;
  logic [mmm_pkg::IDX_W-1:0]         out_col;
  logic                              out_dim_error;
  logic                              out_last;

  product_checker sb = new();

  bit [STORE_DEPTH-1:0] a_written = '0;
  bit [STORE_DEPTH-1:0] b_written = '0;
  int  items_sent  = 0;
  int  starts_sent = 0;
  int  burst_left  = 0;
  int  cycle_count = 0;
  bit  pressure_go = 1'b0;
  bit  long_hold   = 1'b0;

  always #2 clk = ~clk;

  matrix_matrix_multiply dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_element_index  (in_element_index),
    .in_element_value  (in_element_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_product_value (out_product_value),
    .out_row           (out_row),
    .out_col           (out_col),
    .out_dim_error     (out_dim_error),
    .out_last          (out_last)
  );

  // Element values biased toward the Q8.8 extremes
  function automatic logic [mmm_pkg::ELEM_W-1:0] rand_elem();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'hffff;
      3: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Random store position
  function automatic logic [mmm_pkg::ADDR_W-1:0] rand_addr();
    return mmm_pkg::ADDR_W'($urandom_range(0, STORE_DEPTH - 1));
  endfunction

  // Register value for a count; a full-size count may be written oversized
  function automatic logic [mmm_pkg::CFG_DATA_W-1:0] stored(int v, bit wide);
    if (v == mmm_pkg::DIM_CAP && (wide || $urandom_range(0, 3) == 0)) begin
      return wide ? 4'd15 : 4'($urandom_range(mmm_pkg::DIM_CAP + 1, 15));
    end
    return 4'(v);
  endfunction

  // Offer one input item in bursts with random gaps; returns after its transfer
  task automatic send_item(input mmm_pkg::func_t f, input logic [mmm_pkg::ADDR_W-1:0] idx,
                           input logic [mmm_pkg::ELEM_W-1:0] v);
    int gap;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_element_index <= idx;
    in_element_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    items_sent++;
    if (f == mmm_pkg::FUNC_LOAD_A) a_written[idx] = 1'b1;
    if (f == mmm_pkg::FUNC_LOAD_B) b_written[idx] = 1'b1;
    if (f == mmm_pkg::FUNC_START) starts_sent++;
    sb.note_transfer(f, idx, v);
  endtask

  // Stray loads and unused codes
  task automatic noise_item();
    int pick;
    pick = $urandom_range(0, 2);
    send_item(pick == 0 ? mmm_pkg::FUNC_LOAD_A
                        : (pick == 1 ? mmm_pkg::FUNC_LOAD_B : mmm_pkg::FUNC_NONE),
              rand_addr(), rand_elem());
  endtask

  // Wait for the block to go idle before touching the registers
  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (sb.pending_products.size() != 0) @(posedge clk);
    repeat (LAT_PAD) @(posedge clk);
  endtask

  // Write all six registers on consecutive cycles
  task automatic write_config(input logic [mmm_pkg::CFG_DATA_W-1:0] ar, ac, br, bc,
                              input bit ta, tb);
    mmm_pkg::cfg_idx_t              order [6];
    logic [mmm_pkg::CFG_DATA_W-1:0] vals  [6];
    order = '{mmm_pkg::CFG_A_ROWS, mmm_pkg::CFG_A_COLS, mmm_pkg::CFG_B_ROWS,
              mmm_pkg::CFG_B_COLS, mmm_pkg::CFG_TRANSPOSE_A, mmm_pkg::CFG_TRANSPOSE_B};
    vals = '{ar, ac, br, bc, {3'b000, ta}, {3'b000, tb}};
    for (int r = 0; r < 6; r++) begin
      cfg_we <= 1'b1;
      cfg_index <= order[r];
      cfg_data <= vals[r];
      @(posedge clk);
      sb.set_reg(order[r], vals[r]);
    end
    cfg_we <= 1'b0;
  endtask

  // Load entries 0..count-1 in shuffled order; some already written ones are kept
  task automatic fill_store(input mmm_pkg::func_t f, input int count);
    int                   order [STORE_DEPTH];
    int                   s, t;
    bit [STORE_DEPTH-1:0] written;
    written = (f == mmm_pkg::FUNC_LOAD_A) ? a_written : b_written;
    for (int p = 0; p < count; p++) order[p] = p;
    for (int p = count - 1; p > 0; p--) begin
      s = $urandom_range(0, p);
      t = order[p];
      order[p] = order[s];
      order[s] = t;
    end
    for (int p = 0; p < count; p++) begin
      if (!written[order[p]] || $urandom_range(0, 3) != 0) begin
        send_item(f, mmm_pkg::ADDR_W'(order[p]), rand_elem());
      end
    end
  endtask

  // Well-formed job: configure, load both operands, start
  task automatic run_product(input int m, k, n, input bit ta, tb, again, wide);
    int ar, ac, br, bc;
    ar = ta ? k : m;
    ac = ta ? m : k;
    br = tb ? n : k;
    bc = tb ? k : n;
    settle();
    write_config(stored(ar, wide), stored(ac, wide), stored(br, wide), stored(bc, wide),
                 ta, tb);
    fill_store(mmm_pkg::FUNC_LOAD_A, ar * ac);
    fill_store(mmm_pkg::FUNC_LOAD_B, br * bc);
    if ($urandom_range(0, 4) == 0) noise_item();
    send_item(mmm_pkg::FUNC_START, rand_addr(), rand_elem());
    if (wide) pressure_go = 1'b1;
    // items offered while the product is still running
    if (again) send_item(mmm_pkg::FUNC_START, rand_addr(), rand_elem());
    if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 4)) noise_item();
  endtask

  // Inner dimensions that disagree
  task automatic run_mismatch();
    int ar, ac, br, bc, k1, k2;
    bit ta, tb;
    do begin
      ar = $urandom_range(1, mmm_pkg::DIM_CAP);
      ac = $urandom_range(1, mmm_pkg::DIM_CAP);
      br = $urandom_range(1, mmm_pkg::DIM_CAP);
      bc = $urandom_range(1, mmm_pkg::DIM_CAP);
      ta = 1'($urandom_range(0, 1));
      tb = 1'($urandom_range(0, 1));
      k1 = ta ? ar : ac;
      k2 = tb ? bc : br;
    end while (k1 == k2);
    settle();
    write_config(stored(ar, 1'b0), stored(ac, 1'b0), stored(br, 1'b0), stored(bc, 1'b0),
                 ta, tb);
    if ($urandom_range(0, 1) == 0) noise_item();
    send_item(mmm_pkg::FUNC_START, rand_addr(), rand_elem());
  endtask

  // At least one count zero: the start gives nothing
  task automatic run_empty();
    logic [mmm_pkg::CFG_DATA_W-1:0] d [4];
    for (int q = 0; q < 4; q++) d[q] = mmm_pkg::CFG_DATA_W'($urandom_range(0, 15));
    d[$urandom_range(0, 3)] = '0;
    settle();
    write_config(d[0], d[1], d[2], d[3], 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
    send_item(mmm_pkg::FUNC_START, rand_addr(), rand_elem());
  endtask

  // Result side: check each transfer, stall on a changing pattern
  initial begin : result_sink
    int mode, mode_left, phase;
    mode = 0;
    mode_left = 50;
    phase = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        sb.check_product(out_product_value, out_row, out_col, out_dim_error, out_last);
      end
      if (mode_left <= 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      phase++;
      if (long_hold) begin
        out_stall <= 1'b1;
      end else begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 2) == 0);
          2: out_stall <= (phase % 3 == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Long hold-off on the result side while the sender keeps offering
  initial begin : long_hold_off
    wait (pressure_go);
    long_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    long_hold = 1'b0;
  end

  // Cycle limit
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("ERROR: timeout after %0d cycles, %0d results outstanding", cycle_count,
             sb.pending_products.size());
    $display("FAIL");
    $finish;
  end

  // Stimulus
  initial begin : stimulus
    int pick, m, k, n;
    bit big, first;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    settle();

    // 2x2 product with full-scale corners, an entry past the matrix, an unused code
    write_config(4'd2, 4'd2, 4'd2, 4'd2, 1'b0, 1'b0);
    send_item(mmm_pkg::FUNC_LOAD_A, 6'd0, 16'h7fff);
    send_item(mmm_pkg::FUNC_LOAD_A, 6'd1, 16'h8000);
    send_item(mmm_pkg::FUNC_LOAD_A, 6'd2, 16'h0000);
    send_item(mmm_pkg::FUNC_LOAD_A, 6'd3, 16'hffff);
    send_item(mmm_pkg::FUNC_LOAD_B, 6'd0, 16'h8000);
    send_item(mmm_pkg::FUNC_LOAD_B, 6'd1, 16'h8000);
    send_item(mmm_pkg::FUNC_LOAD_B, 6'd2, 16'h7fff);
    send_item(mmm_pkg::FUNC_LOAD_B, 6'd3, 16'h0001);
    send_item(mmm_pkg::FUNC_LOAD_A, 6'd63, 16'h8000);
    send_item(mmm_pkg::FUNC_NONE, 6'd63, 16'hffff);
    send_item(mmm_pkg::FUNC_START, 6'd0, 16'h0000);

    // 2x3 operands, right operand transposed
    settle();
    write_config(4'd2, 4'd3, 4'd2, 4'd3, 1'b0, 1'b1);
    send_item(mmm_pkg::FUNC_LOAD_A, 6'd4, 16'h8000);
    send_item(mmm_pkg::FUNC_LOAD_A, 6'd5, 16'h7fff);
    send_item(mmm_pkg::FUNC_LOAD_B, 6'd4, 16'h8000);
    send_item(mmm_pkg::FUNC_LOAD_B, 6'd5, 16'hffff);
    send_item(mmm_pkg::FUNC_START, 6'd63, 16'hffff);

    // left operand transposed: 3x3 result
    settle();
    write_config(4'd2, 4'd3, 4'd2, 4'd3, 1'b1, 1'b0);
    send_item(mmm_pkg::FUNC_START, 6'd0, 16'h0000);

    // both transposed: inner dimensions disagree
    settle();
    write_config(4'd2, 4'd3, 4'd2, 4'd3, 1'b1, 1'b1);
    send_item(mmm_pkg::FUNC_START, 6'd0, 16'h0000);

    // zero row count: nothing comes out
    settle();
    write_config(4'd0, 4'd3, 4'd2, 4'd3, 1'b0, 1'b0);
    send_item(mmm_pkg::FUNC_START, 6'd0, 16'h0000);

    // random jobs; the first is a full 8x8 with oversized counts and a back-to-back start
    first = 1'b1;
    while (items_sent < ITEMS_TARGET) begin
      pick = $urandom_range(0, 99);
      if (first || pick < 65) begin
        big = ($urandom_range(0, 6) == 0);
        m = first ? mmm_pkg::DIM_CAP
                  : (big ? $urandom_range(5, mmm_pkg::DIM_CAP) : $urandom_range(1, 4));
        k = first ? mmm_pkg::DIM_CAP
                  : (big ? $urandom_range(5, mmm_pkg::DIM_CAP) : $urandom_range(1, 4));
        n = first ? mmm_pkg::DIM_CAP
                  : (big ? $urandom_range(5, mmm_pkg::DIM_CAP) : $urandom_range(1, 4));
        run_product(m, k, n, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    first || ($urandom_range(0, 4) == 0), first);
        first = 1'b0;
      end else if (pick < 80) begin
        run_mismatch();
      end else if (pick < 90) begin
        run_empty();
      end else begin
        repeat ($urandom_range(2, 8)) noise_item();
      end
    end

    // drain
    in_valid <= 1'b0;
    while (sb.pending_products.size() != 0) @(posedge clk);
    repeat (LAT_PAD) @(posedge clk);

    $display("Run covered %0d input transfers (%0d multiply starts) and %0d result transfers",
             items_sent, starts_sent, sb.checked);
    $display("in %0d cycles, with %0d mismatches reported", cycle_count, sb.errors);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/mmm_pkg.sv
sv/mmm_ctrl.sv
sv/mmm_dpath.sv
sv/matrix_matrix_multiply.sv
test/matrix_matrix_multiply_tb.sv
